>>> design/lwbc_pkg.sv
// Package with the sizes, command and status types of the block cache tag engine.
package lwbc_pkg;

  localparam int unsigned SLOTS    = 1024;
  localparam int unsigned ADDR_W   = $clog2(SLOTS);
  localparam int unsigned CNT_W    = ADDR_W + 1;
  localparam int unsigned OFFSET_W = 48;
  localparam int unsigned SLOT_W   = 10;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic capture;
    logic clr_idx;
    logic scan;
    logic decide;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic pass_done;
    logic out_free;
  } status_t;

endpackage

>>> design/lwbc_if.sv
// Handshake interfaces for the request and response channels.
interface lwbc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [47:0] block_offset;
  modport source (output valid, output req_type, output block_offset, input ready);
  modport sink (input valid, input req_type, input block_offset, output ready);
endinterface

interface lwbc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [9:0]  slot;
  logic        flush_needed;
  logic [47:0] evicted_offset;
  modport source (output valid, output hit, output slot, output flush_needed,
                  output evicted_offset, input ready);
  modport sink (input valid, input hit, input slot, input flush_needed,
                input evicted_offset, output ready);
endinterface

>>> design/lwbc_ctrl.sv
// Controller state machine that sequences the tag scan, the decision and the recency pass.
module lwbc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lwbc_pkg::status_t status_i,
  output lwbc_pkg::cmd_t    cmd_o
);
  import lwbc_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.clr_idx = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.pass_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status_i.out_free) begin
          cmd_o.decide  = 1'b1;
          cmd_o.clr_idx = 1'b1;
          state_d       = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        if (status_i.pass_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/lwbc_dpath.sv
// Datapath with the tag, dirty and recency memories, the scan logic and the result register.
module lwbc_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lwbc_pkg::cmd_t                cmd_i,
  output lwbc_pkg::status_t             status_o,
  input  logic                          req_type_i,
  input  logic [lwbc_pkg::OFFSET_W-1:0] block_offset_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          hit_o,
  output logic [lwbc_pkg::SLOT_W-1:0]   slot_o,
  output logic                          flush_needed_o,
  output logic [lwbc_pkg::OFFSET_W-1:0] evicted_offset_o
);
  import lwbc_pkg::*;

  logic [OFFSET_W-1:0] tag_mem   [SLOTS];
  logic                dirty_mem [SLOTS];
  logic [ADDR_W-1:0]   rank_mem  [SLOTS];

  logic                is_write_q;
  logic [OFFSET_W-1:0] tag_q;
  logic [CNT_W-1:0]    used_q;
  logic [CNT_W-1:0]    idx_q;
  logic                rd_vld_q;
  logic [ADDR_W-1:0]   rd_idx_q;
  logic [OFFSET_W-1:0] rd_tag_q;
  logic                rd_dirty_q;
  logic [ADDR_W-1:0]   rd_rank_q;
  logic                found_q;
  logic [ADDR_W-1:0]   hit_slot_q;
  logic [ADDR_W-1:0]   hit_rank_q;
  logic [ADDR_W-1:0]   vic_slot_q;
  logic                vic_dirty_q;
  logic [OFFSET_W-1:0] vic_tag_q;
  logic [ADDR_W-1:0]   sel_slot_q;
  logic [ADDR_W-1:0]   limit_q;
  logic                miss_q;
  logic                out_valid_q;

  logic                rd_en;
  logic                full;
  logic [ADDR_W-1:0]   sel_slot;
  logic                age_we;

  assign rd_en    = (cmd_i.scan || cmd_i.update) && (idx_q != used_q);
  assign full     = (used_q == CNT_W'(SLOTS));
  assign sel_slot = found_q ? hit_slot_q : (full ? vic_slot_q : used_q[ADDR_W-1:0]);
  assign age_we   = cmd_i.update && rd_vld_q && (rd_idx_q != sel_slot_q) &&
                    (miss_q || (rd_rank_q < limit_q));

  assign status_o.pass_done = (idx_q == used_q) && !rd_vld_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_tag_q   <= tag_mem[idx_q[ADDR_W-1:0]];
      rd_dirty_q <= dirty_mem[idx_q[ADDR_W-1:0]];
      rd_rank_q  <= rank_mem[idx_q[ADDR_W-1:0]];
    end
    rd_idx_q <= idx_q[ADDR_W-1:0];
    if (cmd_i.decide) begin
      rank_mem[sel_slot] <= '0;
      if (!found_q) begin
        tag_mem[sel_slot]   <= tag_q;
        dirty_mem[sel_slot] <= is_write_q;
      end else if (is_write_q) begin
        dirty_mem[sel_slot] <= 1'b1;
      end
    end else if (age_we) begin
      rank_mem[rd_idx_q] <= rd_rank_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      is_write_q <= req_type_i;
      tag_q      <= block_offset_i;
    end
    if (cmd_i.scan && rd_vld_q) begin
      if (!found_q && rd_tag_q == tag_q) begin
        hit_slot_q <= rd_idx_q;
        hit_rank_q <= rd_rank_q;
      end
      if (rd_rank_q == ADDR_W'(SLOTS - 1)) begin
        vic_slot_q  <= rd_idx_q;
        vic_dirty_q <= rd_dirty_q;
        vic_tag_q   <= rd_tag_q;
      end
    end
    if (cmd_i.decide) begin
      sel_slot_q       <= sel_slot;
      limit_q          <= hit_rank_q;
      miss_q           <= !found_q;
      hit_o            <= found_q;
      slot_o           <= SLOT_W'(sel_slot);
      flush_needed_o   <= !found_q && full && vic_dirty_q;
      evicted_offset_o <= (!found_q && full && vic_dirty_q) ? vic_tag_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (cmd_i.clr_idx) begin
        idx_q <= '0;
      end else if (rd_en) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (cmd_i.capture) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan && rd_vld_q && rd_tag_q == tag_q) begin
        found_q <= 1'b1;
      end
      if (cmd_i.decide && !found_q && !full) begin
        used_q <= used_q + CNT_W'(1);
      end
      if (cmd_i.decide) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(SLOTS))
    else $error("slot count exceeds the number of slots");

  a_no_flush_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |=> !(hit_o && flush_needed_o))
    else $error("a hit reported a write-back");

  a_age_skips_selected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    age_we |-> (rd_idx_q != sel_slot_q))
    else $error("recency pass aged the selected slot");

  a_decide_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |-> (idx_q == used_q) && !rd_vld_q)
    else $error("decision taken before the tag scan finished");

endmodule

>>> design/lru_writeback_block_cache_tags.sv
// Top level of the fully associative LRU write-back block cache tag engine.
// Requests arrive on the req channel (req_type, block_offset) and one response
// transaction per request leaves on the rsp channel (hit, slot, flush_needed,
// evicted_offset). A request is taken only while the engine is idle.
// Each request runs a tag scan over the used slots, reading one slot a cycle
// from the tag, dirty and recency memories, then a decision cycle that writes
// the chosen slot, then a recency pass over the used slots, again one slot a
// cycle through the single read port of the recency memory.
// The time a request occupies the engine grows with the number of slots in use,
// as both passes visit every used slot, so the rate is set by the number of
// filled slots.
// The response is held in an output register from the decision cycle onwards,
// so a new request may be taken while the previous response waits. If the
// receiver stalls, the next request halts at its decision cycle until the
// register is free.
// Reset empties the cache by clearing the fill count; no clearing pass is
// needed, as only slots below the fill count are ever read.
module lru_writeback_block_cache_tags (
  input logic         clk_i,
  input logic         rst_ni,
  lwbc_req_if.sink    req,
  lwbc_rsp_if.source  rsp
);
  import lwbc_pkg::*;

  cmd_t    cmd;
  status_t status;

  lwbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lwbc_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .req_type_i       (req.req_type),
    .block_offset_i   (req.block_offset),
    .out_ready_i      (rsp.ready),
    .out_valid_o      (rsp.valid),
    .hit_o            (rsp.hit),
    .slot_o           (rsp.slot),
    .flush_needed_o   (rsp.flush_needed),
    .evicted_offset_o (rsp.evicted_offset)
  );

endmodule
